FILE: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = 12;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int STEP_W      = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(511);

  // finished count handed from the iterator to the output stage
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

FILE: hw/rtl/mbe_mul.sv
module mbe_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic                                 step_i,
  input  logic                                 last_i,
  input  logic signed [mbe_pkg::WORD_W-1:0]    a_i,
  input  logic signed [mbe_pkg::WORD_W-1:0]    b_i,
  output logic signed [mbe_pkg::PROD_W-1:0]    prod_o
);
  import mbe_pkg::*;

  localparam int HI_W = WORD_W + 2;
  localparam int P_W  = HI_W + WORD_W;

  // P holds the partial sum on top and the multiplier bits still to scan below
  logic signed [WORD_W-1:0] a_q;
  logic [P_W-1:0]           p_q, p_d;
  logic signed [HI_W-1:0]   addend, hi;

  always_comb begin
    addend = '0;
    if (p_q[0]) begin
      // sign bit of the multiplier weighs -2^(W-1)
      addend = last_i ? -HI_W'(a_q) : HI_W'(a_q);
    end
    hi  = signed'(p_q[P_W-1:WORD_W]) + addend;
    p_d = {hi[HI_W-1], hi, p_q[WORD_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (load_i) begin
      p_q <= {HI_W'(0), b_i};
    end else if (step_i) begin
      p_q <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a_q <= a_i;
    end
  end

  assign prod_o = signed'(p_q[PROD_W-1:0]);

endmodule

FILE: hw/rtl/mbe_iter.sv
module mbe_iter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mbe_pkg::WORD_W-1:0]        c_real_i,
  input  logic [mbe_pkg::WORD_W-1:0]        c_imag_i,
  input  logic [mbe_pkg::CNT_W-1:0]         limit_i,
  output logic                              idle_o,
  output mbe_pkg::res_t                     res_o,
  input  logic                              res_ready_i
);
  import mbe_pkg::*;

  localparam int DW = PROD_W + 1;
  localparam int SW = DW - FRAC_BITS;
  localparam int NW = ((SW > WORD_W) ? SW : WORD_W) + 1;
  localparam logic signed [NW-1:0] SAT_MAX = NW'(64'sd2147483647);
  localparam logic signed [NW-1:0] SAT_MIN = NW'(-64'sd2147483648);

  typedef enum logic [2:0] {IDLE, LOAD, MUL, EVAL, UPD, DONE} state_e;

  state_e                  state_q;
  logic [STEP_W-1:0]       step_q;
  logic [CNT_W-1:0]        n_q;
  logic signed [WORD_W-1:0] cr_q, ci_q, x_q, y_q;
  logic signed [DW-1:0]    diff_q;
  logic signed [PROD_W-1:0] xy_q;
  logic                    inside_q;

  logic signed [PROD_W-1:0] xx, yy, xy;
  logic [PROD_W-1:0]       sumsq;
  logic signed [NW-1:0]    nr, ni;
  logic signed [WORD_W-1:0] nr_sat, ni_sat;
  logic                    mload, mstep, mlast;

  assign mload = (state_q == LOAD);
  assign mstep = (state_q == MUL);
  assign mlast = (step_q == STEP_W'(WORD_W - 1));

  mbe_mul u_mul_xx (.clk_i, .rst_ni, .load_i(mload), .step_i(mstep), .last_i(mlast),
                    .a_i(x_q), .b_i(x_q), .prod_o(xx));
  mbe_mul u_mul_yy (.clk_i, .rst_ni, .load_i(mload), .step_i(mstep), .last_i(mlast),
                    .a_i(y_q), .b_i(y_q), .prod_o(yy));
  mbe_mul u_mul_xy (.clk_i, .rst_ni, .load_i(mload), .step_i(mstep), .last_i(mlast),
                    .a_i(x_q), .b_i(y_q), .prod_o(xy));

  always_comb begin
    // squares are non-negative, so the sum fits unsigned
    sumsq = xx + yy;
    // arithmetic shift is floor; xy scaled by 2 via one shift less
    nr = NW'(signed'(diff_q[DW-1:FRAC_BITS])) + NW'(cr_q);
    ni = NW'(signed'(xy_q[PROD_W-1:FRAC_BITS-1])) + NW'(ci_q);
    priority if (nr > SAT_MAX) nr_sat = SAT_MAX[WORD_W-1:0];
    else if (nr < SAT_MIN)     nr_sat = SAT_MIN[WORD_W-1:0];
    else                       nr_sat = nr[WORD_W-1:0];
    priority if (ni > SAT_MAX) ni_sat = SAT_MAX[WORD_W-1:0];
    else if (ni < SAT_MIN)     ni_sat = SAT_MIN[WORD_W-1:0];
    else                       ni_sat = ni[WORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      step_q  <= '0;
      n_q     <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (start_i) begin
            n_q     <= '0;
            state_q <= LOAD;
          end
        end
        LOAD: begin
          step_q  <= '0;
          state_q <= MUL;
        end
        MUL: begin
          step_q <= step_q + STEP_W'(1);
          if (mlast) begin
            state_q <= EVAL;
          end
        end
        EVAL: state_q <= UPD;
        UPD: begin
          if (n_q < limit_i && inside_q) begin
            n_q     <= n_q + CNT_W'(1);
            state_q <= LOAD;
          end else begin
            state_q <= DONE;
          end
        end
        DONE: begin
          if (res_ready_i) begin
            state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == IDLE && start_i) begin
      cr_q <= signed'(c_real_i);
      ci_q <= signed'(c_imag_i);
      x_q  <= signed'(c_real_i);
      y_q  <= signed'(c_imag_i);
    end else if (state_q == UPD && n_q < limit_i && inside_q) begin
      x_q <= nr_sat;
      y_q <= ni_sat;
    end
    if (state_q == EVAL) begin
      // |z|^2 < 4 with 2F fraction bits
      inside_q <= (sumsq[PROD_W-1:2*FRAC_BITS+2] == '0);
      diff_q   <= DW'(xx) - DW'(yy);
      xy_q     <= xy;
    end
  end

  assign idle_o      = (state_q == IDLE);
  assign res_o.valid = (state_q == DONE);
  assign res_o.count = n_q;

endmodule

FILE: hw/rtl/mandelbrot_escape_time_core.sv
// Channel   Direction  Ports                        Payload (low bit up)
// s_axis    in         tvalid/tready/tdata[63:0]    point_real[31:0], point_imag[63:32]
// m_axis    out        tvalid/tready/tdata[15:0]    escape_count[11:0], zero pad
// cfg       in         cfg_we_i, cfg_wdata_i[11:0]  iteration_limit
//
// Each iteration steps through LOAD, MUL, EVAL and UPD; MUL runs the bit-serial 32-step multiplier.
// A point runs escape_count + 1 iterations after accept; DONE then loads the output register (tvalid).
// One point is worked at a time; tready is high only while the iterator idles.
// The output register holds a result under stall while the next point runs.
// Reset sets the limit to 511 and empties the output register.
module mandelbrot_escape_time_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // point_real, point_imag
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // escape_count, pad
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i
);
  import mbe_pkg::*;

  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] count_q;
  logic             oval_q;
  logic             idle, res_ready;
  res_t             res;

  assign res_ready = !oval_q || m_axis_tready_i;

  mbe_iter u_iter (
    .clk_i,
    .rst_ni,
    .start_i     (s_axis_tvalid_i && idle),
    .c_real_i    (s_axis_tdata_i[WORD_W-1:0]),
    .c_imag_i    (s_axis_tdata_i[2*WORD_W-1:WORD_W]),
    .limit_i     (limit_q),
    .idle_o      (idle),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      oval_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        oval_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      count_q <= res.count;
    end
  end

  assign s_axis_tready_o = idle;
  assign m_axis_tvalid_o = oval_q;
  assign m_axis_tdata_o  = {(16 - CNT_W)'(0), count_q};

endmodule

FILE: hw/rtl/mbe_checker.sv
module mbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed under stall");

  a_one_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while a point is in work");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:12] == 4'd0)
    else $error("pad bits of result not zero");

endmodule

bind mandelbrot_escape_time_core mbe_checker u_mbe_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid_i,
  .s_axis_tready_o,
  .m_axis_tvalid_o,
  .m_axis_tready_i,
  .m_axis_tdata_o
);

FILE: verif/tb_mandelbrot_escape_time_core.sv
module tb_mandelbrot_escape_time_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  localparam int  IDLE_LIMIT = 1000000;
  localparam int  RAND_ITEMS = 1150;
  localparam logic [CNT_W-1:0] LIMIT_ZERO = '0;
  localparam logic [CNT_W-1:0] LIMIT_TOP  = '1;
  localparam logic signed [WORD_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [WORD_W-1:0] WMAX  = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] WMIN  = 32'sh80000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;

  mandelbrot_escape_time_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  logic [CNT_W-1:0] iter_limit = LIMIT_RESET;
  logic [CNT_W-1:0] pending_counts[$];
  logic [CNT_W-1:0] cand_count;
  int unsigned      mismatches = 0;
  int unsigned      points_sent = 0;
  int unsigned      counts_seen = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      hold_req = 0;
  int unsigned      hold_left = 0;
  int unsigned      deepest = 0;

  function automatic longint clamp_word(longint v);
    if (v > longint'(WMAX)) return longint'(WMAX);
    if (v < longint'(WMIN)) return longint'(WMIN);
    return v;
  endfunction

  // iterate z = z*z + c, escape test on exact |z|^2 before each step
  function automatic logic [CNT_W-1:0] escape_iters(logic signed [WORD_W-1:0] cr,
                                                    logic signed [WORD_W-1:0] ci,
                                                    logic [CNT_W-1:0] lim);
    longint     x, y, xx, yy, xy;
    logic [64:0] mag;
    logic [CNT_W-1:0] n;
    bit         run;
    x = cr;
    y = ci;
    n = '0;
    run = 1'b1;
    while (run && n < lim) begin
      xx = x * x;
      yy = y * y;
      mag = {1'b0, xx} + {1'b0, yy};
      if (mag >= (65'd1 << (2 * FRAC_BITS + 2))) begin
        run = 1'b0;
      end else begin
        xy = x * y;
        x = clamp_word(((xx - yy) >>> FRAC_BITS) + longint'(cr));
        y = clamp_word((xy >>> (FRAC_BITS - 1)) + longint'(ci));
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_coord();
    logic signed [WORD_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0:       return v;                // full range, mostly far outside
      1, 2:    return v >>> 2;          // within +-2
      3:       return v >>> 3;          // within +-1
      default: return (v >>> 4) - (ONE_Q >>> 1);  // around the main body
    endcase
  endfunction

  // one point per call; sender bursts and gaps handled here
  task automatic send_point(logic signed [WORD_W-1:0] cr, logic signed [WORD_W-1:0] ci);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ci, cr};
    cand_count = escape_iters(cr, ci, iter_limit);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_counts.push_back(cand_count);
    points_sent++;
    if (cand_count > deepest) deepest = cand_count;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_counts.size() != 0);
  endtask

  task automatic set_limit(logic [CNT_W-1:0] lim);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    iter_limit = lim;
  endtask

  task automatic test_reset_limit();
    send_point('0, '0);                       // inside, runs to 511
    send_point(-(ONE_Q <<< 1), '0);           // |c|^2 == 4 exactly
    send_point(WMAX, WMAX);
    send_point(WMIN, WMIN);
    send_point(WMAX, WMIN);
    send_point(-ONE_Q, '0);                   // orbit alternates between 0 and -1, inside
    wait_drained();
  endtask

  task automatic test_edge_points();
    set_limit(12'd20);
    send_point(ONE_Q >>> 2, '0);              // cusp, slow
    send_point(-(ONE_Q <<< 1) + 1, '0);       // just inside the radius
    send_point('0, (ONE_Q <<< 1) - 1);
    send_point(ONE_Q, ONE_Q);
    send_point(ONE_Q >>> 1, ONE_Q >>> 1);
    send_point(-ONE_Q - (ONE_Q >>> 2), ONE_Q >>> 3);
    send_point(32'sh1, 32'sh1);
    send_point(-32'sh1, -32'sh1);
    send_point('0, ONE_Q);                    // i, periodic
    send_point(32'sh55555555 >>> 2, 32'shaaaaaaaa >>> 2);
  endtask

  task automatic test_limit_extremes();
    set_limit(LIMIT_ZERO);
    send_point('0, '0);
    send_point(ONE_Q, '0);
    set_limit(12'd1);
    send_point('0, '0);
    send_point(WMIN, '0);
    set_limit(LIMIT_TOP);
    send_point('0, '0);                       // inside, runs to 4095
    send_point(ONE_Q >>> 2, ONE_Q >>> 1);
  endtask

  task automatic test_backpressure();
    set_limit(12'd4);
    hold_req = 3000;
    repeat (12) send_point(rand_coord(), rand_coord());
    wait_drained();
  endtask

  task automatic test_random();
    logic signed [WORD_W-1:0] cr, ci;
    int unsigned n;
    n = 0;
    while (n < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       set_limit(12'd1);
        1:       set_limit(LIMIT_TOP);
        2:       set_limit(12'd64);
        default: set_limit(12'($urandom_range(2, 24)));
      endcase
      repeat ($urandom_range(60, 140)) begin
        cr = rand_coord();
        ci = rand_coord();
        // keep long runs rare when the limit is high
        if (n < RAND_ITEMS &&
            (escape_iters(cr, ci, iter_limit) <= 40 || $urandom_range(0, 199) == 0)) begin
          send_point(cr, ci);
          n++;
        end
      end
    end
    wait_drained();
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      counts_seen++;
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected count %0d", $time, m_axis_tdata_o[CNT_W-1:0]);
        mismatches++;
      end else begin
        if (m_axis_tdata_o[CNT_W-1:0] !== pending_counts[0]) begin
          $display("%0t: escape_count expected %0d actual %0d", $time,
                   pending_counts[0], m_axis_tdata_o[CNT_W-1:0]);
          mismatches++;
        end
        void'(pending_counts.pop_front());
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (rst_ni) begin
      // phases of full speed, light and heavy stalling
      case (($time / 4000) % 3)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready_i <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d counts outstanding", $time, pending_counts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limit();
    test_edge_points();
    test_limit_extremes();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk_i);
    $display("Points sent %0d, counts checked %0d, deepest count %0d, limits 0 to 4095.",
             points_sent, counts_seen, deepest);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_mul.sv
hw/rtl/mbe_iter.sv
hw/rtl/mandelbrot_escape_time_core.sv
hw/rtl/mbe_checker.sv
verif/tb_mandelbrot_escape_time_core.sv
